// ===== hdl/tcs_pkg.sv =====
package tcs_pkg;

  // Geometry of the byte store and the character screen
  localparam int MEM_DEPTH    = 65536;
  localparam int SCREEN_BASE  = 4096;
  localparam int LINE_WIDTH   = 64;
  localparam int LINE_COUNT   = 32;
  localparam int BITMAP_END   = 12288;
  localparam int CONTROL_BASE = 256;

  localparam int MEM_AW = $clog2(MEM_DEPTH);
  localparam int PTR_W  = MEM_AW + 1;

  localparam int SCR_END_I  = SCREEN_BASE + LINE_WIDTH * LINE_COUNT;
  localparam int SCR_LAST_I = SCREEN_BASE + LINE_WIDTH * (LINE_COUNT - 1);
  localparam int SHELL_END_I = (SCR_END_I > MEM_DEPTH) ? MEM_DEPTH : SCR_END_I;
  localparam int BMP_END_I   = (BITMAP_END > MEM_DEPTH) ? MEM_DEPTH : BITMAP_END;

  localparam logic [PTR_W-1:0] SCR_BASE_P  = PTR_W'(SCREEN_BASE);
  localparam logic [PTR_W-1:0] SCR_END_P   = PTR_W'(SCR_END_I);
  localparam logic [PTR_W-1:0] SCR_LAST_P  = PTR_W'(SCR_LAST_I);
  localparam logic [PTR_W-1:0] SHELL_END_P = PTR_W'(SHELL_END_I);
  localparam logic [PTR_W-1:0] BMP_END_P   = PTR_W'(BMP_END_I);
  localparam logic [PTR_W-1:0] MEM_LAST_P  = PTR_W'(MEM_DEPTH - 1);

  localparam logic [MEM_AW-1:0] ROW_IDX  = MEM_AW'(CONTROL_BASE);
  localparam logic [MEM_AW-1:0] COL_IDX  = MEM_AW'(CONTROL_BASE + 1);
  localparam logic [MEM_AW-1:0] MODE_IDX = MEM_AW'(CONTROL_BASE + 2);

  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_NEWLINE = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_PUT     = 3'd4,
    CMD_BEGIN   = 3'd5,
    CMD_TEXT    = 3'd6,
    CMD_NOP     = 3'd7
  } cmd_e_t;

  typedef enum logic [1:0] {
    SEL_CURSOR = 2'd0,
    SEL_LINE   = 2'd1,
    SEL_ADDR   = 2'd2,
    SEL_RSVD   = 2'd3
  } sel_e_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
    logic [7:0]  text_length;
    logic        prefix_newline;
    logic [1:0]  start_select;
    logic        last_char;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] scrolled_lines;
    logic [7:0] cursor_row;
    logic [7:0] cursor_col;
  } rsp_t;

  // One datapath operation per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_INIT,
    OP_LOAD,
    OP_WRITE,
    OP_READ,
    OP_PUT,
    OP_TEXT,
    OP_NL_ONE,
    OP_NL_LINES,
    OP_NL_ROW,
    OP_NL_COL,
    OP_SC_INIT,
    OP_SC_RD,
    OP_SC_WR,
    OP_SC_BLANK,
    OP_CLR_INIT,
    OP_CLR,
    OP_BT_START,
    OP_BT_PTR,
    OP_FINISH
  } op_t;

  typedef struct packed {
    op_t op;
  } ctl_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       pre;
    logic       tail_nl;
    logic       nl_zero;
    logic       row_last;
    logic       copy_done;
    logic       blank_done;
    logic       clr_done;
    logic       init_last;
    logic       out_free;
  } sts_t;

endpackage

// ===== hdl/text_console_scroll_engine.sv =====
// Text console engine over a 64 KiB byte store holding a 32 x 64 character
// screen at 0x1000; cursor row, column and screen mode live in the control
// bytes at 0x100..0x102 and may be written directly. One result beat per
// request beat, in order. After reset the store is swept to zero, one byte a
// cycle, before the first request is taken. The store is single-port, one
// access a cycle. Each scroll copies 31 lines, reading then writing each
// byte, and blanks one line; clear writes one byte a cycle, over the screen
// lines in shell mode or from 0x1000 up to 0x3000 in bitmap mode.
// A new request is taken as soon as the previous result is registered,
// even while that result still waits on result_ready.
module text_console_scroll_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          request_valid,
  output logic          request_ready,
  input  tcs_pkg::req_t request,
  output logic          result_valid,
  input  logic          result_ready,
  output tcs_pkg::rsp_t result
);
  import tcs_pkg::*;

  ctl_t ctl;  // per-cycle datapath operation
  sts_t sts;  // item fields and loop status back to the FSM

  tcs_controller u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .sts           (sts),
    .ctl           (ctl)
  );

  // store, control-byte mirrors, text pointer, result register
  tcs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .sts          (sts),
    .request      (request),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

endmodule

// ===== hdl/tcs_datapath.sv =====
module tcs_datapath (
  input  logic          clk,
  input  logic          rst,
  input  tcs_pkg::ctl_t ctl,
  output tcs_pkg::sts_t sts,
  input  tcs_pkg::req_t request,
  output tcs_pkg::rsp_t result,
  output logic          result_valid,
  input  logic          result_ready
);
  import tcs_pkg::*;

  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        mem_q;
  req_t              item;
  logic [PTR_W-1:0]  ptr;
  logic [PTR_W-1:0]  clr_end;
  logic [7:0]        nl_cnt;
  logic [7:0]        grp;
  logic [7:0]        sc;
  logic [15:0]       tp;
  logic [15:0]       start_q;
  logic [7:0]        row;
  logic [7:0]        col;
  logic [7:0]        mode;

  logic              we;
  logic              re;
  logic [MEM_AW-1:0] widx;
  logic [MEM_AW-1:0] ridx;
  logic [7:0]        wdat;
  logic [15:0]       line_addr;
  logic [15:0]       cur_addr;
  logic [8:0]        lines;
  logic [7:0]        lines_m1;
  logic [15:0]       start_sel;
  logic [15:0]       back_off;

  assign line_addr = 16'(SCREEN_BASE) + 16'(16'(row) * 16'(LINE_WIDTH));
  assign cur_addr  = line_addr + 16'(col);
  assign lines     = 9'((10'(item.text_length) + 10'(LINE_WIDTH - 1)) / LINE_WIDTH);
  assign lines_m1  = (lines == 9'd0) ? 8'd0 : 8'(lines - 9'd1);
  assign back_off  = 16'(16'(LINE_WIDTH) * 16'(grp));

  always_comb begin
    case (sel_e_t'(item.start_select))
      SEL_ADDR: start_sel = item.address;
      SEL_LINE: start_sel = line_addr;
      default:  start_sel = cur_addr;
    endcase
  end

  // memory port selection
  always_comb begin
    we   = 1'b0;
    re   = 1'b0;
    widx = '0;
    ridx = '0;
    wdat = '0;
    case (ctl.op)
      OP_INIT: begin
        we   = 1'b1;
        widx = ptr[MEM_AW-1:0];
      end
      OP_WRITE: begin
        we   = 1'b1;
        widx = item.address[MEM_AW-1:0];
        wdat = item.data;
      end
      OP_READ: begin
        re   = 1'b1;
        ridx = item.address[MEM_AW-1:0];
      end
      OP_PUT: begin
        we   = 1'b1;
        widx = cur_addr[MEM_AW-1:0];
        wdat = item.data;
      end
      OP_TEXT: begin
        we   = 1'b1;
        widx = tp[MEM_AW-1:0];
        wdat = item.data;
      end
      OP_NL_ROW: begin
        we   = 1'b1;
        widx = ROW_IDX;
        wdat = row + 8'd1;
      end
      OP_NL_COL: begin
        we   = 1'b1;
        widx = COL_IDX;
      end
      OP_SC_RD: begin
        re   = 1'b1;
        ridx = MEM_AW'(ptr + PTR_W'(LINE_WIDTH));
      end
      OP_SC_WR: begin
        we   = 1'b1;
        widx = ptr[MEM_AW-1:0];
        wdat = mem_q;
      end
      OP_SC_BLANK, OP_CLR: begin
        we   = 1'b1;
        widx = ptr[MEM_AW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[widx] <= wdat;
    end
    if (re) begin
      mem_q <= mem[ridx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.op == OP_LOAD) begin
      item <= request;
    end
    if (ctl.op == OP_CLR_INIT) begin
      clr_end <= (mode != 8'd0) ? BMP_END_P : SHELL_END_P;
    end
    if (ctl.op == OP_BT_START) begin
      start_q <= start_sel;
    end
    if (ctl.op == OP_FINISH) begin
      result.read_data      <= (cmd_e_t'(item.command) == CMD_READ) ? mem_q : 8'd0;
      result.scrolled_lines <= sc;
      result.cursor_row     <= row;
      result.cursor_col     <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr          <= '0;
      tp           <= '0;
      row          <= '0;
      col          <= '0;
      mode         <= '0;
      sc           <= '0;
      nl_cnt       <= '0;
      grp          <= '0;
      result_valid <= 1'b0;
    end else begin
      // control bytes mirrored from every store write
      if (we && widx == ROW_IDX)  row  <= wdat;
      if (we && widx == COL_IDX)  col  <= wdat;
      if (we && widx == MODE_IDX) mode <= wdat;

      if (ctl.op == OP_FINISH) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end

      case (ctl.op)
        OP_INIT:     ptr <= ptr + PTR_W'(1);
        OP_LOAD:     sc  <= '0;
        OP_TEXT:     tp  <= tp + 16'd1;
        OP_NL_ONE: begin
          nl_cnt <= 8'd1;
          grp    <= '0;
        end
        OP_NL_LINES: begin
          nl_cnt <= lines_m1;
          grp    <= '0;
        end
        OP_NL_ROW:   nl_cnt <= nl_cnt - 8'd1;
        OP_SC_INIT: begin
          ptr    <= SCR_BASE_P;
          nl_cnt <= nl_cnt - 8'd1;
          grp    <= grp + 8'd1;
          if (sc != 8'hFF) sc <= sc + 8'd1;
        end
        OP_SC_WR, OP_SC_BLANK, OP_CLR: ptr <= ptr + PTR_W'(1);
        OP_CLR_INIT: ptr <= SCR_BASE_P;
        OP_BT_PTR:   tp  <= start_q - back_off;
        default: ;
      endcase
    end
  end

  assign sts.cmd        = item.command;
  assign sts.pre        = item.prefix_newline;
  assign sts.tail_nl    = (cmd_e_t'(item.command) == CMD_TEXT) ? item.last_char
                                                              : (item.text_length == 8'd0);
  assign sts.nl_zero    = (nl_cnt == 8'd0);
  assign sts.row_last   = (row >= 8'(LINE_COUNT - 1));
  assign sts.copy_done  = (ptr == SCR_LAST_P);
  assign sts.blank_done = (ptr == SCR_END_P);
  assign sts.clr_done   = (ptr >= clr_end);
  assign sts.init_last  = (ptr == MEM_LAST_P);
  assign sts.out_free   = !result_valid || result_ready;

endmodule

// ===== hdl/tcs_controller.sv =====
module tcs_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          request_valid,
  output logic          request_ready,
  input  tcs_pkg::sts_t sts,
  output tcs_pkg::ctl_t ctl
);
  import tcs_pkg::*;

  typedef enum logic [12:0] {
    S_INIT     = 13'b0000000000001,
    S_IDLE     = 13'b0000000000010,
    S_EXEC     = 13'b0000000000100,
    S_NL       = 13'b0000000001000,
    S_SC_RD    = 13'b0000000010000,
    S_SC_WR    = 13'b0000000100000,
    S_SC_BLANK = 13'b0000001000000,
    S_CLEAR    = 13'b0000010000000,
    S_BT_START = 13'b0000100000000,
    S_BT_LINES = 13'b0001000000000,
    S_BT_PTR   = 13'b0010000000000,
    S_TAIL     = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  typedef enum logic [1:0] {
    RET_DONE,
    RET_BT_START,
    RET_BT_PTR
  } ret_t;

  state_t state, state_next;
  ret_t   ret, ret_next;

  assign request_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    ctl.op     = OP_NONE;
    case (state)
      S_INIT: begin
        ctl.op = OP_INIT;
        if (sts.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (request_valid) begin
          ctl.op     = OP_LOAD;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (cmd_e_t'(sts.cmd))
          CMD_WRITE: begin
            ctl.op     = OP_WRITE;
            state_next = S_DONE;
          end
          CMD_READ: begin
            ctl.op     = OP_READ;
            state_next = S_DONE;
          end
          CMD_NEWLINE: begin
            ctl.op     = OP_NL_ONE;
            ret_next   = RET_DONE;
            state_next = S_NL;
          end
          CMD_CLEAR: begin
            ctl.op     = OP_CLR_INIT;
            state_next = S_CLEAR;
          end
          CMD_PUT: begin
            ctl.op     = OP_PUT;
            state_next = S_DONE;
          end
          CMD_BEGIN: begin
            if (sts.pre) begin
              ctl.op     = OP_NL_ONE;
              ret_next   = RET_BT_START;
              state_next = S_NL;
            end else begin
              state_next = S_BT_START;
            end
          end
          CMD_TEXT: begin
            ctl.op     = OP_TEXT;
            state_next = S_TAIL;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_NL: begin
        if (sts.nl_zero) begin
          ctl.op = OP_NL_COL;
          case (ret)
            RET_BT_START: state_next = S_BT_START;
            RET_BT_PTR:   state_next = S_BT_PTR;
            default:      state_next = S_DONE;
          endcase
        end else if (sts.row_last) begin
          ctl.op     = OP_SC_INIT;
          state_next = S_SC_RD;
        end else begin
          ctl.op = OP_NL_ROW;
        end
      end
      S_SC_RD: begin
        if (sts.copy_done) begin
          state_next = S_SC_BLANK;
        end else begin
          ctl.op     = OP_SC_RD;
          state_next = S_SC_WR;
        end
      end
      S_SC_WR: begin
        ctl.op     = OP_SC_WR;
        state_next = S_SC_RD;
      end
      S_SC_BLANK: begin
        if (sts.blank_done) begin
          state_next = S_NL;
        end else begin
          ctl.op = OP_SC_BLANK;
        end
      end
      S_CLEAR: begin
        if (sts.clr_done) begin
          state_next = S_DONE;
        end else begin
          ctl.op = OP_CLR;
        end
      end
      S_BT_START: begin
        ctl.op     = OP_BT_START;
        state_next = S_BT_LINES;
      end
      S_BT_LINES: begin
        ctl.op     = OP_NL_LINES;
        ret_next   = RET_BT_PTR;
        state_next = S_NL;
      end
      S_BT_PTR: begin
        ctl.op     = OP_BT_PTR;
        state_next = S_TAIL;
      end
      S_TAIL: begin
        if (sts.tail_nl) begin
          ctl.op     = OP_NL_ONE;
          ret_next   = RET_DONE;
          state_next = S_NL;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.op     = OP_FINISH;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      ret   <= RET_DONE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (request_valid && request_ready) |=> (state == S_EXEC))
    else $error("accepted beat did not start execution");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    (ctl.op == OP_FINISH) |-> sts.out_free)
    else $error("result register overwritten");

  a_copy_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_SC_WR) |-> ($past(state) == S_SC_RD))
    else $error("scroll write without preceding read");

endmodule
